// ===== hdl/prr_pkg.sv =====
// shared constants, types and elaboration-time helpers for the permutation rank/unrank block
// no dependencies; imported by every module of the block
`default_nettype none

package prr_pkg;

    localparam int N_ELEMENTS = 9;
    localparam int DIGIT_W    = 4;
    localparam int PERM_W     = N_ELEMENTS * DIGIT_W;
    localparam int INDEX_W    = 19;
    localparam int CNT_W      = $clog2(N_ELEMENTS + 1);

    typedef logic [DIGIT_W-1:0]                   t_digit;
    typedef logic [N_ELEMENTS-1:0][DIGIT_W-1:0]   t_digits;
    typedef logic [N_ELEMENTS-1:0][INDEX_W-1:0]   t_row;
    typedef logic [N_ELEMENTS-1:0]                t_used;

    typedef enum logic {
        OP_RANK   = 1'b0,
        OP_UNRANK = 1'b1
    } t_op;

    // one request as it travels down the chain
    typedef struct packed {
        t_op                op;
        logic               bad;
        t_used              used;
        logic [INDEX_W-1:0] acc;
        logic [PERM_W-1:0]  perm;
    } t_item;

    function automatic int unsigned fact(input int k);
        int unsigned f;
        f = 1;
        for (int i = 2; i <= k; i++) begin
            f = f * i;
        end
        return f;
    endfunction

    // multiples 0..N-1 of the weight (N-1-stage)! used by one stage
    function automatic t_row weight_row(input int stage);
        t_row r;
        for (int k = 0; k < N_ELEMENTS; k++) begin
            r[k] = INDEX_W'(k * fact(N_ELEMENTS - 1 - stage));
        end
        return r;
    endfunction

    function automatic logic [PERM_W-1:0] identity_perm();
        logic [PERM_W-1:0] v;
        for (int i = 0; i < N_ELEMENTS; i++) begin
            v[i*DIGIT_W +: DIGIT_W] = DIGIT_W'(i);
        end
        return v;
    endfunction

    localparam logic [INDEX_W-1:0] INDEX_LIMIT = INDEX_W'(fact(N_ELEMENTS));
    localparam logic [PERM_W-1:0]  BASE_RESET  = identity_perm();

endpackage

`default_nettype wire

// ===== hdl/prr_base_decode.sv =====
// base permutation register and its registered inverse map and sanity flag
// depends on prr_pkg
`default_nettype none

module prr_base_decode (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [prr_pkg::PERM_W-1:0] i_cfg_data,
    output prr_pkg::t_digits            o_digits,
    output prr_pkg::t_digits            o_pos,
    output logic                        o_base_bad
);
    import prr_pkg::*;

    logic [PERM_W-1:0] r_base;
    t_digits           r_pos, n_pos;
    logic              r_base_bad, n_base_bad;

    assign o_cfg_ready = 1'b1;
    assign o_digits    = r_base;
    assign o_pos       = r_pos;
    assign o_base_bad  = r_base_bad;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_data;
        end
    end

    // position of each digit, and a flag when some digit is missing or repeated
    always_comb begin
        logic [CNT_W-1:0] hits;
        n_pos      = '0;
        n_base_bad = 1'b0;
        hits       = '0;
        for (int d = 0; d < N_ELEMENTS; d++) begin
            hits = '0;
            for (int i = 0; i < N_ELEMENTS; i++) begin
                if (r_base[i*DIGIT_W +: DIGIT_W] == DIGIT_W'(d)) begin
                    n_pos[d] = n_pos[d] | DIGIT_W'(i);
                    hits     = hits + 1'b1;
                end
            end
            if (hits != CNT_W'(1)) begin
                n_base_bad = 1'b1;
            end
        end
    end

    // derived copy is registered, so it follows the base register in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_bad <= 1'b0;
        end else begin
            r_base_bad <= n_base_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
    end

endmodule

`default_nettype wire

// ===== hdl/prr_entry.sv =====
// entry stage: registers a request, checks the index range and seeds the chain
// depends on prr_pkg
`default_nettype none

module prr_entry (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_op,
    input  wire logic [prr_pkg::PERM_W-1:0]  i_perm_in,
    input  wire logic [prr_pkg::INDEX_W-1:0] i_index_in,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output prr_pkg::t_item                   o_item
);
    import prr_pkg::*;

    logic  r_valid;
    t_item r_item, n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // rank starts from zero, unrank starts from the requested index
    always_comb begin
        n_item.op   = t_op'(i_op);
        n_item.bad  = (n_item.op == OP_UNRANK) && (i_index_in >= INDEX_LIMIT);
        n_item.used = '0;
        n_item.acc  = (n_item.op == OP_UNRANK) ? i_index_in : '0;
        n_item.perm = i_perm_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/prr_cell.sv =====
// one position of the factorial-base code: a registered stage of the chain
// depends on prr_pkg; weight row, inverse base map and base digits come from the top level
`default_nettype none

module prr_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire prr_pkg::t_item   i_item,
    input  wire prr_pkg::t_row    i_row,
    input  wire prr_pkg::t_digits i_pos,
    input  wire prr_pkg::t_digits i_digits,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output prr_pkg::t_item        o_item
);
    import prr_pkg::*;

    logic  r_valid;
    t_item r_item, n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // low nibble is this position; the word shifts right and the unranked digit enters on top
    always_comb begin
        t_digit             d;
        t_digit             d_idx;
        t_digit             p;
        logic               digit_ok;
        logic [CNT_W-1:0]   cnt;
        logic [CNT_W-1:0]   q;
        logic [CNT_W-1:0]   free_below;
        logic [CNT_W-1:0]   pick;
        logic               found;
        logic [INDEX_W-1:0] rem;

        n_item   = i_item;
        d        = i_item.perm[DIGIT_W-1:0];
        digit_ok = d < DIGIT_W'(N_ELEMENTS);
        d_idx    = digit_ok ? d : '0;
        p        = i_pos[d_idx];

        // rank: unused positions below p
        cnt = '0;
        for (int j = 0; j < N_ELEMENTS; j++) begin
            if ((DIGIT_W'(j) < p) && !i_item.used[j]) begin
                cnt = cnt + 1'b1;
            end
        end

        // unrank: digit of the remaining index in this radix
        q = '0;
        for (int k = 1; k < N_ELEMENTS; k++) begin
            if (i_item.acc >= i_row[k]) begin
                q = q + 1'b1;
            end
        end
        rem = i_item.acc - i_row[q];

        // unrank: the q-th free position, counted from zero
        pick       = CNT_W'(N_ELEMENTS - 1);
        found      = 1'b0;
        free_below = '0;
        for (int j = 0; j < N_ELEMENTS; j++) begin
            if (!i_item.used[j]) begin
                if (!found && (free_below == q)) begin
                    pick  = CNT_W'(j);
                    found = 1'b1;
                end
                free_below = free_below + 1'b1;
            end
        end

        case (i_item.op)
            OP_RANK: begin
                n_item.bad     = i_item.bad | !digit_ok | i_item.used[p];
                n_item.used[p] = 1'b1;
                n_item.acc     = i_item.acc + i_row[cnt];
                n_item.perm    = {DIGIT_W'(0), i_item.perm[PERM_W-1:DIGIT_W]};
            end
            OP_UNRANK: begin
                n_item.used[pick] = 1'b1;
                n_item.acc        = rem;
                n_item.perm       = {i_digits[pick], i_item.perm[PERM_W-1:DIGIT_W]};
            end
            default: begin
                n_item = i_item;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/permutation_rank_unrank.sv =====
// top level: entry stage, chain of position cells, base decode and result register
// depends on prr_pkg, prr_base_decode, prr_entry, prr_cell
//
//   channel   direction  handshake                  payload
//   request   in         i_valid / o_stall          i_op, i_perm_in, i_index_in
//   result    out        o_valid / i_stall          o_index_out, o_perm_out, o_invalid
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (base permutation)
//
// one request per cycle sustained while the result side is not stalled; a request passes the entry
// register, one cell per position, and the result register
// each stage takes a new request when it is empty or its successor moves, so bubbles close up
// o_stall rises only when every stage is full and the result is stalled
// reset empties the pipe and loads the identity as base; no clearing pass
// the base decode is registered, so a request may follow a config write in the next cycle
`default_nettype none

module permutation_rank_unrank (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_op,
    input  wire logic [prr_pkg::PERM_W-1:0]  i_perm_in,
    input  wire logic [prr_pkg::INDEX_W-1:0] i_index_in,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [prr_pkg::INDEX_W-1:0]      o_index_out,
    output logic [prr_pkg::PERM_W-1:0]       o_perm_out,
    output logic                             o_invalid,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [prr_pkg::PERM_W-1:0]  i_cfg_data
);
    import prr_pkg::*;

    t_digits               w_digits, w_pos;
    logic                  w_base_bad;
    logic                  w_in_ready;
    logic [N_ELEMENTS:0]   w_valid, w_ready;
    t_item                 w_item [N_ELEMENTS+1];
    t_item                 w_last;
    logic                  w_bad;
    logic                  w_out_ready;

    logic                  r_out_valid;
    logic [INDEX_W-1:0]    r_index, n_index;
    logic [PERM_W-1:0]     r_perm, n_perm;
    logic                  r_invalid;

    // base register and decode
    prr_base_decode u_base (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_digits    (w_digits),
        .o_pos       (w_pos),
        .o_base_bad  (w_base_bad)
    );

    // entry stage
    prr_entry u_entry (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (w_in_ready),
        .i_op       (i_op),
        .i_perm_in  (i_perm_in),
        .i_index_in (i_index_in),
        .o_valid    (w_valid[0]),
        .i_ready    (w_ready[0]),
        .o_item     (w_item[0])
    );

    assign o_stall = !w_in_ready;

    // one cell per position
    for (genvar k = 0; k < N_ELEMENTS; k++) begin : g_cell
        localparam t_row ROW = weight_row(k);
        prr_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_valid[k]),
            .o_ready  (w_ready[k]),
            .i_item   (w_item[k]),
            .i_row    (ROW),
            .i_pos    (w_pos),
            .i_digits (w_digits),
            .o_valid  (w_valid[k+1]),
            .i_ready  (w_ready[k+1]),
            .o_item   (w_item[k+1])
        );
    end

    // result selection: only the field of the request's mode, zero when rejected
    assign w_last      = w_item[N_ELEMENTS];
    assign w_bad       = w_last.bad | w_base_bad;
    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_ready[N_ELEMENTS] = w_out_ready;

    always_comb begin
        n_index = (!w_bad && (w_last.op == OP_RANK))   ? w_last.acc  : '0;
        n_perm  = (!w_bad && (w_last.op == OP_UNRANK)) ? w_last.perm : '0;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_valid[N_ELEMENTS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && w_valid[N_ELEMENTS]) begin
            r_index   <= n_index;
            r_perm    <= n_perm;
            r_invalid <= w_bad;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_index_out = r_index;
    assign o_perm_out  = r_perm;
    assign o_invalid   = r_invalid;

    // checks
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_valid[0])
        else $error("accepted request missing from entry stage");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&w_valid) && r_out_valid && i_stall))
        else $error("input stalled while the pipe has room");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> ((o_index_out == '0) && (o_perm_out == '0)))
        else $error("rejected result carries nonzero fields");

    a_rank_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_invalid) |-> (o_index_out < INDEX_LIMIT))
        else $error("rank beyond factorial range");

endmodule

`default_nettype wire

// ===== tb/sv/prr_conversion_checker.sv =====
`timescale 1ns / 100ps
// checker for the permutation rank/unrank block: watches all three channels, predicts each result
// and compares it with what comes out; depends on prr_pkg only
module prr_conversion_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_req_valid,
    input  wire logic                        i_req_stall,
    input  wire logic                        i_op,
    input  wire logic [prr_pkg::PERM_W-1:0]  i_perm_in,
    input  wire logic [prr_pkg::INDEX_W-1:0] i_index_in,
    input  wire logic                        i_res_valid,
    input  wire logic                        i_res_stall,
    input  wire logic [prr_pkg::INDEX_W-1:0] i_index_out,
    input  wire logic [prr_pkg::PERM_W-1:0]  i_perm_out,
    input  wire logic                        i_invalid,
    input  wire logic                        i_cfg_valid,
    input  wire logic                        i_cfg_ready,
    input  wire logic [prr_pkg::PERM_W-1:0]  i_cfg_data,
    output int                               o_pending,
    output int                               o_fail_count
);
    import prr_pkg::*;

    typedef struct packed {
        logic [INDEX_W-1:0] index_out;
        logic [PERM_W-1:0]  perm_out;
        logic               invalid;
    } t_conversion;

    logic [PERM_W-1:0] base_perm;
    t_conversion       pending_conversions[$];
    t_conversion       oldest;
    int                mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic int unsigned factorial(input int k);
        int unsigned f;
        f = 1;
        while (k > 1) begin
            f = f * k;
            k = k - 1;
        end
        return f;
    endfunction

    // fills the position of every digit; false when the low nibbles are not a permutation
    function automatic bit digit_slots(input logic [PERM_W-1:0] v, output int unsigned slot_of[16]);
        bit seen[16];
        int unsigned d;
        for (int i = 0; i < 16; i++) begin
            seen[i]    = 1'b0;
            slot_of[i] = 0;
        end
        for (int i = 0; i < N_ELEMENTS; i++) begin
            d = v[i*DIGIT_W +: DIGIT_W];
            if (d >= N_ELEMENTS || seen[d]) return 1'b0;
            seen[d]    = 1'b1;
            slot_of[d] = i;
        end
        return 1'b1;
    endfunction

    // expected result of one request under the given base
    function automatic t_conversion convert(input t_op op, input logic [PERM_W-1:0] perm,
                                            input logic [INDEX_W-1:0] index,
                                            input logic [PERM_W-1:0] base);
        t_conversion res;
        int unsigned base_slot[16];
        int unsigned perm_slot[16];
        bit          taken[16];
        bit          reject;
        bit          found;
        int unsigned rank;
        int unsigned remain;
        int unsigned weight;
        int unsigned slot;
        int unsigned smaller;
        res    = '0;
        rank   = 0;
        for (int i = 0; i < 16; i++) taken[i] = 1'b0;
        reject = !digit_slots(base, base_slot);
        if (op == OP_RANK) begin
            if (!reject && !digit_slots(perm, perm_slot)) reject = 1'b1;
            if (!reject) begin
                for (int i = 0; i < N_ELEMENTS; i++) begin
                    slot    = base_slot[perm[i*DIGIT_W +: DIGIT_W]];
                    smaller = 0;
                    for (int j = 0; j < slot; j++) begin
                        if (!taken[j]) smaller++;
                    end
                    rank        = rank + smaller * factorial(N_ELEMENTS - 1 - i);
                    taken[slot] = 1'b1;
                end
                res.index_out = INDEX_W'(rank);
            end
        end else begin
            if (index >= factorial(N_ELEMENTS)) reject = 1'b1;
            if (!reject) begin
                remain = index;
                for (int i = 0; i < N_ELEMENTS; i++) begin
                    weight = factorial(N_ELEMENTS - 1 - i);
                    slot   = N_ELEMENTS - 1;
                    found  = 1'b0;
                    // walk the free positions, spending one weight per skipped one
                    for (int j = 0; j < N_ELEMENTS; j++) begin
                        if (!found && !taken[j]) begin
                            if (weight > remain) begin
                                slot  = j;
                                found = 1'b1;
                            end else begin
                                remain = remain - weight;
                            end
                        end
                    end
                    taken[slot] = 1'b1;
                    res.perm_out[i*DIGIT_W +: DIGIT_W] = base[slot*DIGIT_W +: DIGIT_W];
                end
            end
        end
        if (reject) res = '0;
        res.invalid = reject;
        return res;
    endfunction

    // track the base, queue predictions, compare results in order
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_perm = BASE_RESET;
            pending_conversions.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) base_perm = i_cfg_data;
            if (i_res_valid && !i_res_stall) begin
                if (pending_conversions.size() == 0) begin
                    $error("unexpected result: index_out %0d perm_out %h invalid %0b",
                           i_index_out, i_perm_out, i_invalid);
                    mismatches++;
                end else begin
                    oldest = pending_conversions.pop_front();
                    if (i_index_out !== oldest.index_out) begin
                        $error("index_out: expected %0d, actual %0d", oldest.index_out,
                               i_index_out);
                        mismatches++;
                    end
                    if (i_perm_out !== oldest.perm_out) begin
                        $error("perm_out: expected %h, actual %h", oldest.perm_out, i_perm_out);
                        mismatches++;
                    end
                    if (i_invalid !== oldest.invalid) begin
                        $error("invalid: expected %0b, actual %0b", oldest.invalid, i_invalid);
                        mismatches++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                pending_conversions.push_back(convert(t_op'(i_op), i_perm_in, i_index_in,
                                                      base_perm));
            end
        end
        o_pending <= pending_conversions.size();
    end

endmodule

// ===== tb/sv/permutation_rank_unrank_tb.sv =====
`timescale 1ns / 100ps
// top of the permutation rank/unrank testbench: clock, reset, request and base writes,
// result stalls, watchdog and verdict; depends on prr_pkg, the block and prr_conversion_checker
module permutation_rank_unrank_tb;
    import prr_pkg::*;

    localparam int unsigned PERM_COUNT = 362880;
    localparam int unsigned INDEX_TOP  = (1 << INDEX_W) - 1;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          DRAIN_GAP  = 14;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_op;
    logic [PERM_W-1:0]  i_perm_in;
    logic [INDEX_W-1:0] i_index_in;
    logic               o_valid;
    logic               i_stall;
    logic [INDEX_W-1:0] o_index_out;
    logic [PERM_W-1:0]  o_perm_out;
    logic               o_invalid;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [PERM_W-1:0]  i_cfg_data;

    int pending;
    int fail_count;
    int quiet_cycles = 0;
    bit idling       = 1'b1;

    permutation_rank_unrank u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_perm_in   (i_perm_in),
        .i_index_in  (i_index_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_index_out (o_index_out),
        .o_perm_out  (o_perm_out),
        .o_invalid   (o_invalid),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    prr_conversion_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_op         (i_op),
        .i_perm_in    (i_perm_in),
        .i_index_in   (i_index_in),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_index_out  (o_index_out),
        .i_perm_out   (o_perm_out),
        .i_invalid    (o_invalid),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result side stalls in random bursts while idling is on
    initial begin
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (idling && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [PERM_W-1:0] random_bits();
        return PERM_W'({$urandom(), $urandom()});
    endfunction

    // uniform permutation of the digits by swapping
    function automatic logic [PERM_W-1:0] shuffled_perm();
        logic [DIGIT_W-1:0] d[N_ELEMENTS];
        logic [DIGIT_W-1:0] t;
        logic [PERM_W-1:0]  v;
        int                 j;
        for (int i = 0; i < N_ELEMENTS; i++) d[i] = DIGIT_W'(i);
        for (int i = N_ELEMENTS - 1; i > 0; i--) begin
            j    = $urandom_range(0, i);
            t    = d[i];
            d[i] = d[j];
            d[j] = t;
        end
        v = '0;
        for (int i = 0; i < N_ELEMENTS; i++) v[i*DIGIT_W +: DIGIT_W] = d[i];
        return v;
    endfunction

    // one request; valid stays high on return so back-to-back requests need no bubble
    task automatic send_request(input t_op op, input logic [PERM_W-1:0] perm,
                                input logic [INDEX_W-1:0] index);
        if (idling && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_perm_in  <= perm;
        i_index_in <= index;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_random_request();
        int unsigned        kind;
        logic [PERM_W-1:0]  perm;
        logic [INDEX_W-1:0] junk_index;
        kind       = $urandom_range(0, 99);
        junk_index = INDEX_W'($urandom_range(0, INDEX_TOP));
        if (kind < 45) begin
            send_request(OP_RANK, shuffled_perm(), junk_index);
        end else if (kind < 55) begin
            // broken permutation: raw bits, or one digit overwritten
            if ($urandom_range(0, 1)) begin
                perm = random_bits();
            end else begin
                perm = shuffled_perm();
                perm[$urandom_range(0, N_ELEMENTS - 1)*DIGIT_W +: DIGIT_W] =
                    DIGIT_W'($urandom_range(0, 15));
            end
            send_request(OP_RANK, perm, junk_index);
        end else if (kind < 90) begin
            send_request(OP_UNRANK, random_bits(), INDEX_W'($urandom_range(0, PERM_COUNT - 1)));
        end else begin
            send_request(OP_UNRANK, random_bits(),
                         INDEX_W'($urandom_range(PERM_COUNT, INDEX_TOP)));
        end
    endtask

    task automatic send_random_block(input int count);
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) idling = ($urandom_range(0, 3) != 0);
            send_random_request();
        end
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [PERM_W-1:0] value);
        drain();
        repeat (DRAIN_GAP) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_op        <= OP_RANK;
        i_perm_in   <= '0;
        i_index_in  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed requests on the identity base after reset
        send_request(OP_RANK, 36'h876543210, INDEX_W'(INDEX_TOP));
        send_request(OP_RANK, 36'h012345678, '0);
        send_request(OP_RANK, 36'h786543210, '0);
        send_request(OP_RANK, 36'h000000000, '0);
        send_request(OP_RANK, 36'hfffffffff, INDEX_W'(INDEX_TOP));
        send_request(OP_RANK, 36'h876543290, '0);
        send_request(OP_RANK, 36'h876543211, '0);
        send_request(OP_RANK, 36'h8765432f0, '0);
        send_request(OP_RANK, shuffled_perm(), '0);
        send_request(OP_UNRANK, 36'hfffffffff, '0);
        send_request(OP_UNRANK, '0, INDEX_W'(PERM_COUNT - 1));
        send_request(OP_UNRANK, '0, INDEX_W'(PERM_COUNT));
        send_request(OP_UNRANK, '0, INDEX_W'(INDEX_TOP));
        send_request(OP_UNRANK, '0, INDEX_W'(1));
        send_request(OP_UNRANK, '0, INDEX_W'($urandom_range(0, PERM_COUNT - 1)));
        send_random_block(160);

        // reversed base: the old top rank becomes zero
        write_base(36'h012345678);
        send_request(OP_RANK, 36'h012345678, '0);
        send_request(OP_UNRANK, '0, '0);
        send_random_block(120);

        write_base(shuffled_perm());
        send_random_block(150);

        // bad bases reject everything
        write_base(36'hfffffffff);
        send_request(OP_RANK, 36'h876543210, '0);
        send_request(OP_UNRANK, '0, '0);
        send_random_block(20);
        write_base(36'h000000000);
        send_random_block(20);

        // back to identity; the tail runs without any idling
        write_base(BASE_RESET);
        send_random_block(60);
        idling = 1'b0;
        for (int k = 0; k < 100; k++) send_random_request();

        drain();
        repeat (DRAIN_GAP) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/prr_pkg.sv
hdl/prr_base_decode.sv
hdl/prr_entry.sv
hdl/prr_cell.sv
hdl/permutation_rank_unrank.sv
tb/sv/prr_conversion_checker.sv
tb/sv/permutation_rank_unrank_tb.sv
